/* design/sme_pkg.sv */
// sme_pkg: shared constants, codes and types for the stack machine executor
// depends on nothing; every other design file imports it
`default_nettype none

package sme_pkg;

   // stack geometry
   localparam int WORD_WIDTH  = 32;
   localparam int STACK_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

   // fixed widths of the transaction fields
   localparam int CMD_W     = 4;
   localparam int OPERAND_W = 32;
   localparam int DEPTH_W   = 11;
   localparam int CHAR_W    = 8;

   // instruction codes
   localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_ADD   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SUB   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_DIV   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_MUL   = 4'd5;
   localparam logic [CMD_W-1:0] CMD_ENTER = 4'd6;
   localparam logic [CMD_W-1:0] CMD_TEST  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_PRINT = 4'd8;
   localparam logic [CMD_W-1:0] CMD_EXIT  = 4'd9;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_FULL  = 3'd1,
      STATUS_UNDER = 3'd2,
      STATUS_DIVZ  = 3'd3,
      STATUS_HALT  = 3'd4
   } status_type;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      logic [CMD_W-1:0]            cmd;
      logic signed [OPERAND_W-1:0] operand;
      logic                        emit_xor;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic signed [OPERAND_W-1:0] top_value;
      logic [DEPTH_W-1:0]          depth;
      logic                        equal;
      logic [CHAR_W-1:0]           char_out;
      logic                        char_valid;
      logic                        halted_out;
   } rsp_type;

   // datapath selections
   typedef enum logic [1:0] {SRC_OPND, SRC_ALU, SRC_DIV} src_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_type;
   typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL} alu_type;
   typedef enum logic [2:0] {TOP_KEEP, TOP_OPND, TOP_ALU, TOP_DIV, TOP_BELOW} top_type;

   // what one committed instruction does to the stack and the response
   typedef struct packed {
      status_type status;
      logic       wr_en;
      src_type    wr_src;
      cnt_type    cnt_op;
      alu_type    alu_op;
      top_type    top_sel;
      logic       set_halt;
      logic       test_eq;
      logic       emit_char;
   } act_type;

   // controller to datapath
   typedef struct packed {
      logic    capture;
      logic    div_start;
      logic    commit;
      act_type act;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic lt2;
      logic full;
      logic a_zero;
      logic halted;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

/* design/stack_machine_executor.sv */
// stack_machine_executor: top level, joins the sequencer and the datapath
// depends on sme_pkg, sme_ctrl, sme_dpath (and sme_div below it)
//
// Usage
//   Each req transaction carries one instruction (cmd, operand, emit_xor);
//   each produces exactly one rsp transaction with the status, the new top of
//   stack, the depth and the test, emit and halt flags.
//   One instruction is in flight at a time. req_ready is high while the block
//   waits for an instruction. The stack entries live in a 1024 x 32 memory
//   whose two registered read ports present the top two entries.
//   rsp_valid rises when the instruction commits: from the execute step for every
//   instruction but a successful divide, which goes through a bit-serial divider
//   and commits from the divide step once the divider reports done.
//   A new instruction is taken only after the previous one has committed.
//   The response sits in an output register: a new instruction is taken while
//   an earlier response still waits, and it only holds at its commit step
//   if rsp_ready is still low.
//   Reset (synchronous, active high) empties the stack, clears the halt state
//   and drops rsp_valid; stack memory is not cleared and needs no sweep.
//   After an exit instruction every further instruction returns halted.
`default_nettype none

module stack_machine_executor (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  sme_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output sme_pkg::rsp_type  rsp_payload
);
   import sme_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   sme_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .dp_status   (dp_status),
      .cmd         (cmd)
   );

   sme_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* design/sme_div.sv */
// sme_div: iterative signed divider, one quotient bit per cycle, truncating
// depends on sme_pkg for the word width
`default_nettype none

module sme_div (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  sme_pkg::word_type   dividend,
   input  sme_pkg::word_type   divisor,
   output logic                done,
   output sme_pkg::word_type   quotient
);
   import sme_pkg::*;

   localparam int DIV_CW = $clog2(WORD_WIDTH + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CW-1:0]     cnt_ff;
   logic [WORD_WIDTH-1:0] rem_ff;
   logic [WORD_WIDTH-1:0] quo_ff;
   logic [WORD_WIDTH-1:0] dvs_ff;
   logic                  neg_ff;
   logic [WORD_WIDTH:0]   trial;
   logic [WORD_WIDTH:0]   diff;
   logic [WORD_WIDTH-1:0] dvd_mag;
   logic [WORD_WIDTH-1:0] dvs_mag;

   // operand magnitudes; the most negative value maps onto its own pattern
   assign dvd_mag = dividend[WORD_WIDTH-1] ? (~dividend + 1'b1) : dividend;
   assign dvs_mag = divisor[WORD_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

   // restoring step
   assign trial = {rem_ff, quo_ff[WORD_WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == DIV_CW'(1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   // shift and subtract
   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= DIV_CW'(WORD_WIDTH);
         rem_ff <= '0;
         quo_ff <= dvd_mag;
         dvs_ff <= dvs_mag;
         neg_ff <= dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (!diff[WORD_WIDTH]) begin
            rem_ff <= diff[WORD_WIDTH-1:0];
            quo_ff <= {quo_ff[WORD_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= trial[WORD_WIDTH-1:0];
            quo_ff <= {quo_ff[WORD_WIDTH-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? word_type'(~quo_ff + 1'b1) : word_type'(quo_ff);

endmodule

`default_nettype wire

/* design/sme_dpath.sv */
// sme_dpath: stack memory, depth and halt state, alu, divider and response register
// depends on sme_pkg and sme_div
`default_nettype none

module sme_dpath (
   input  wire                    clock,
   input  wire                    reset,
   input  sme_pkg::req_type       req_payload,
   input  sme_pkg::ctrl_cmd_type  cmd,
   output sme_pkg::dp_status_type dp_status,
   output sme_pkg::rsp_type       rsp_payload
);
   import sme_pkg::*;

   word_type               stack_mem [STACK_DEPTH];
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   logic                   halted_ff;
   word_type               a_ff;
   word_type               b_ff;
   word_type               opnd_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic [ADDR_W-1:0]      addr_a;
   logic [ADDR_W-1:0]      addr_b;
   word_type               alu_res;
   word_type               div_q;
   word_type               wr_data;
   logic                   div_done;

   // top and second entry addresses
   assign addr_a = ADDR_W'(count_ff - COUNT_W'(1));
   assign addr_b = ADDR_W'(count_ff - COUNT_W'(2));

   // stack memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.commit && cmd.act.wr_en) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= wr_data;
      end
      a_ff <= stack_mem[addr_a];
      b_ff <= stack_mem[addr_b];
   end

   // operand capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opnd_ff <= WORD_WIDTH'(req_payload.operand);
      end
   end

   // alu, result is b op a
   always_comb begin
      case (cmd.act.alu_op)
         ALU_SUB: alu_res = b_ff - a_ff;
         ALU_MUL: alu_res = b_ff * a_ff;
         default: alu_res = b_ff + a_ff;
      endcase
   end

   sme_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (b_ff),
      .divisor  (a_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // write data select
   always_comb begin
      case (cmd.act.wr_src)
         SRC_ALU: wr_data = alu_res;
         SRC_DIV: wr_data = div_q;
         default: wr_data = opnd_ff;
      endcase
   end

   // next depth
   always_comb begin
      case (cmd.act.cnt_op)
         CNT_INC: count_in = count_ff + 1'b1;
         CNT_DEC: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // depth and halt state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         if (cmd.act.set_halt) begin
            halted_ff <= 1'b1;
         end
      end
   end

   // response build
   always_comb begin
      rsp_in            = '0;
      rsp_in.status     = cmd.act.status;
      rsp_in.depth      = DEPTH_W'(count_in);
      rsp_in.equal      = cmd.act.test_eq && (a_ff == b_ff);
      rsp_in.char_out   = cmd.act.emit_char ? CHAR_W'(a_ff ^ b_ff) : '0;
      rsp_in.char_valid = cmd.act.emit_char;
      rsp_in.halted_out = halted_ff | cmd.act.set_halt;
      case (cmd.act.top_sel)
         TOP_OPND:  rsp_in.top_value = OPERAND_W'(opnd_ff);
         TOP_ALU:   rsp_in.top_value = OPERAND_W'(alu_res);
         TOP_DIV:   rsp_in.top_value = OPERAND_W'(div_q);
         TOP_BELOW: rsp_in.top_value = (count_ff == COUNT_W'(1)) ? '0 : OPERAND_W'(b_ff);
         default:   rsp_in.top_value = (count_ff == '0) ? '0 : OPERAND_W'(a_ff);
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // status to the controller
   assign dp_status.empty    = (count_ff == '0);
   assign dp_status.lt2      = (count_ff < COUNT_W'(2));
   assign dp_status.full     = (count_ff >= COUNT_W'(STACK_DEPTH));
   assign dp_status.a_zero   = (a_ff == '0);
   assign dp_status.halted   = halted_ff;
   assign dp_status.div_done = div_done;

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* design/sme_ctrl.sv */
// sme_ctrl: instruction sequencer, decodes one transaction and drives the datapath
// depends on sme_pkg
`default_nettype none

module sme_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  sme_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  sme_pkg::dp_status_type dp_status,
   output sme_pkg::ctrl_cmd_type  cmd
);
   import sme_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [CMD_W-1:0]  op_ff;
   logic              xor_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              slot_free;
   logic              need_div;
   act_type           dec;
   act_type           div_act;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // decode against the current stack state
   always_comb begin
      dec         = '0;
      dec.status  = STATUS_OK;
      dec.wr_src  = SRC_OPND;
      dec.cnt_op  = CNT_HOLD;
      dec.alu_op  = ALU_ADD;
      dec.top_sel = TOP_KEEP;
      need_div    = 1'b0;
      if (dp_status.halted) begin
         dec.status = STATUS_HALT;
      end else if (xor_ff) begin
         if (dp_status.lt2) begin
            dec.status = STATUS_UNDER;
         end else begin
            dec.emit_char = 1'b1;
         end
      end else begin
         case (op_ff)
            CMD_PUSH, CMD_ENTER: begin
               if (dp_status.full) begin
                  dec.status = STATUS_FULL;
               end else begin
                  dec.wr_en   = 1'b1;
                  dec.cnt_op  = CNT_INC;
                  dec.top_sel = TOP_OPND;
               end
            end
            CMD_POP: begin
               if (dp_status.empty) begin
                  dec.status = STATUS_UNDER;
               end else begin
                  dec.cnt_op  = CNT_DEC;
                  dec.top_sel = TOP_BELOW;
               end
            end
            CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL: begin
               if (dp_status.lt2) begin
                  dec.status = STATUS_UNDER;
               end else if (op_ff == CMD_DIV && dp_status.a_zero) begin
                  dec.status = STATUS_DIVZ;
               end else if (dp_status.full) begin
                  dec.status = STATUS_FULL;
               end else if (op_ff == CMD_DIV) begin
                  need_div = 1'b1;
               end else begin
                  dec.wr_en   = 1'b1;
                  dec.wr_src  = SRC_ALU;
                  dec.cnt_op  = CNT_INC;
                  dec.top_sel = TOP_ALU;
                  if (op_ff == CMD_SUB) begin
                     dec.alu_op = ALU_SUB;
                  end else if (op_ff == CMD_MUL) begin
                     dec.alu_op = ALU_MUL;
                  end
               end
            end
            CMD_TEST: begin
               if (dp_status.lt2) begin
                  dec.status = STATUS_UNDER;
               end else begin
                  dec.test_eq = 1'b1;
                  dec.cnt_op  = CNT_DEC;
                  dec.top_sel = TOP_BELOW;
               end
            end
            CMD_PRINT: begin
               if (dp_status.empty) begin
                  dec.status = STATUS_UNDER;
               end
            end
            CMD_EXIT: begin
               dec.set_halt = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // commit of a finished division
   always_comb begin
      div_act         = '0;
      div_act.status  = STATUS_OK;
      div_act.wr_en   = 1'b1;
      div_act.wr_src  = SRC_DIV;
      div_act.cnt_op  = CNT_INC;
      div_act.alu_op  = ALU_ADD;
      div_act.top_sel = TOP_DIV;
   end

   // sequencing and datapath commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.act     = dec;
      cmd.capture = req_valid && req_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.act = div_act;
            if (dp_status.div_done && slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.capture) begin
         op_ff  <= req_payload.cmd;
         xor_ff <= req_payload.emit_xor;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/sme_checker.sv */
// sme_checker: port-level checks over time for the stack machine executor
// depends on sme_pkg; bound to stack_machine_executor at the end of this file
`default_nettype none

module sme_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input sme_pkg::req_type  req_payload,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input sme_pkg::rsp_type  rsp_payload
);
   import sme_pkg::*;

   logic seen_halt_ff;
   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // a halted response has gone out
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_fire && rsp_payload.halted_out) begin
         seen_halt_ff <= 1'b1;
      end
   end

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // once halted, always halted
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_halt_ff |->
         rsp_payload.status == STATUS_HALT && rsp_payload.halted_out)
      else $error("instruction executed after exit");

   // depth within the stack
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.depth <= DEPTH_W'(STACK_DEPTH))
      else $error("depth beyond stack size");

   // empty stack reports zero top
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.depth == '0 |-> rsp_payload.top_value == '0)
      else $error("non-zero top on empty stack");

   // failed instructions carry no flags
   a_fail_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |->
         !rsp_payload.char_valid && !rsp_payload.equal && rsp_payload.char_out == '0)
      else $error("flags set on a failed instruction");

   logic unused_req;
   assign unused_req = req_fire ^ (^req_payload);

endmodule

bind stack_machine_executor sme_checker u_sme_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

/* bench/stack_machine_executor_checker.sv */
// stack_machine_executor_checker: watches both channels of the executor, predicts each response
// and compares it field by field; depends on sme_pkg only
`timescale 1ns / 1ps

module stack_machine_executor_checker (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   input  wire              req_ready,
   input  sme_pkg::req_type req_payload,
   input  wire              rsp_valid,
   input  wire              rsp_ready,
   input  sme_pkg::rsp_type rsp_payload,
   output int               failures,
   output int               outstanding
);
   import sme_pkg::*;

   // shadow copy of the machine state
   word_type    stack_words [STACK_DEPTH];
   int unsigned stack_count;
   logic        halted_flag;

   rsp_type     instruction_results [$];
   int          mismatch_total;

   // run one instruction on the shadow stack and return the response it gives
   function automatic rsp_type execute_instruction(input req_type item);
      rsp_type    res;
      status_type st;
      word_type   a, b, r;
      logic       eq, chv;
      logic [7:0] ch;
      st  = STATUS_OK;
      eq  = 1'b0;
      chv = 1'b0;
      ch  = '0;
      r   = '0;
      a   = (stack_count > 0) ? stack_words[stack_count - 1] : '0;
      b   = (stack_count > 1) ? stack_words[stack_count - 2] : '0;
      if (halted_flag) begin
         st = STATUS_HALT;
      end else if (item.emit_xor) begin
         // xor-emit wins over whatever cmd holds
         if (stack_count < 2) begin
            st = STATUS_UNDER;
         end else begin
            r   = a ^ b;
            ch  = r[7:0];
            chv = 1'b1;
         end
      end else begin
         case (item.cmd)
            CMD_PUSH, CMD_ENTER: begin
               if (stack_count >= STACK_DEPTH) begin
                  st = STATUS_FULL;
               end else begin
                  stack_words[stack_count] = item.operand;
                  stack_count++;
               end
            end
            CMD_POP: begin
               if (stack_count == 0) st = STATUS_UNDER;
               else stack_count--;
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
               // underflow, then divide by zero, then full
               if (stack_count < 2) begin
                  st = STATUS_UNDER;
               end else if (item.cmd == CMD_DIV && a == 0) begin
                  st = STATUS_DIVZ;
               end else if (stack_count >= STACK_DEPTH) begin
                  st = STATUS_FULL;
               end else begin
                  case (item.cmd)
                     CMD_ADD: r = b + a;
                     CMD_SUB: r = b - a;
                     CMD_MUL: r = b * a;
                     // most negative over minus one wraps to itself
                     default: r = (a == -1) ? -b : b / a;
                  endcase
                  stack_words[stack_count] = r;
                  stack_count++;
               end
            end
            CMD_TEST: begin
               if (stack_count < 2) begin
                  st = STATUS_UNDER;
               end else begin
                  eq = (a == b);
                  stack_count--;
               end
            end
            CMD_PRINT: begin
               if (stack_count == 0) st = STATUS_UNDER;
            end
            CMD_EXIT: begin
               halted_flag = 1'b1;
            end
            default: begin
               // spare codes leave everything as it is
            end
         endcase
      end
      res.status     = st;
      res.top_value  = (stack_count > 0) ? stack_words[stack_count - 1] : '0;
      res.depth      = DEPTH_W'(stack_count);
      res.equal      = eq;
      res.char_out   = ch;
      res.char_valid = chv;
      res.halted_out = halted_flag;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatch_total++;
         $display("%0t: rsp %s expected 0x%08h actual 0x%08h", $time, field, want, got);
      end
   endtask

   // compare responses first, then record the new prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stack_count    = 0;
         halted_flag    = 1'b0;
         mismatch_total = 0;
         instruction_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (instruction_results.size() == 0) begin
               mismatch_total++;
               $display("%0t: rsp transaction with no instruction outstanding", $time);
            end else begin
               want = instruction_results.pop_front();
               compare_field("status", want.status, rsp_payload.status);
               compare_field("top_value", want.top_value, rsp_payload.top_value);
               compare_field("depth", want.depth, rsp_payload.depth);
               compare_field("equal", want.equal, rsp_payload.equal);
               compare_field("char_out", want.char_out, rsp_payload.char_out);
               compare_field("char_valid", want.char_valid, rsp_payload.char_valid);
               compare_field("halted_out", want.halted_out, rsp_payload.halted_out);
            end
         end
         if (req_valid && req_ready)
            instruction_results.push_back(execute_instruction(req_payload));
      end
      failures    <= mismatch_total;
      outstanding <= instruction_results.size();
   end

endmodule

/* bench/stack_machine_executor_tb.sv */
// stack_machine_executor_tb: drives instructions and response back-pressure into the executor
// and gives the verdict; depends on sme_pkg, stack_machine_executor and the checker module
`timescale 1ns / 1ps

module stack_machine_executor_tb;
   import sme_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 200;
   localparam int DRAIN_CYCLES  = 60;
   localparam int DEPTH_GUARD   = 40;

   // codes the block leaves unused
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

   localparam word_type WORD_MIN = 32'sh8000_0000;
   localparam word_type WORD_MAX = 32'sh7fff_ffff;

   localparam logic [CMD_W-1:0] ARITH_OPS [4] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV};
   localparam int IDLE_PCT  [4] = '{0, 88, 0, 7};
   localparam int STALL_PCT [4] = '{0, 0, 88, 7};

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    rsp_ready   = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_payload;

   int             fail_count;
   int             outstanding;
   int             req_idle_pct  = 0;
   int             rsp_stall_pct = 0;
   bit             hold_requested = 1'b0;
   int             quiet_cycles;
   logic [DEPTH_W-1:0] last_depth;

   stack_machine_executor dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   stack_machine_executor_checker results_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .failures    (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response back-pressure, with a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requested) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_requested = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // depth seen on the last response, used to steer the random mix
   always @(posedge clock) begin
      if (reset) last_depth <= '0;
      else if (rsp_valid && rsp_ready) last_depth <= rsp_payload.depth;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic [CMD_W-1:0] cmd, input word_type value,
                                        input logic emit);
      req_type r;
      r.cmd      = cmd;
      r.operand  = value;
      r.emit_xor = emit;
      return r;
   endfunction

   // operands lean towards the corners of the word
   function automatic word_type pick_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return -1;
         2: return WORD_MIN;
         3: return WORD_MAX;
         4: return $signed($urandom_range(0, 20)) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_push();
      return $urandom_range(0, 1) ? CMD_PUSH : CMD_ENTER;
   endfunction

   // offer one transaction, with random idle cycles in front of it
   task automatic send_req(input req_type item);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering until every response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      // underflow on an empty stack
      send_req(make_req(CMD_POP, WORD_MAX, 1'b0));
      send_req(make_req(CMD_PRINT, WORD_MIN, 1'b0));
      send_req(make_req(CMD_ADD, '0, 1'b0));
      send_req(make_req(CMD_TEST, -1, 1'b0));
      send_req(make_req(CMD_PUSH, 32'sh1234_5678, 1'b1));
      // one entry: still short for binary operations
      send_req(make_req(CMD_PUSH, WORD_MAX, 1'b0));
      send_req(make_req(CMD_DIV, '0, 1'b0));
      send_req(make_req(CMD_EXIT, '0, 1'b1));
      // wrap on add, most negative over minus one, wrap on multiply
      send_req(make_req(CMD_ENTER, 32'sd1, 1'b0));
      send_req(make_req(CMD_ADD, '0, 1'b0));
      send_req(make_req(CMD_PUSH, -1, 1'b0));
      send_req(make_req(CMD_DIV, '0, 1'b0));
      send_req(make_req(CMD_MUL, '0, 1'b0));
      send_req(make_req(CMD_SUB, '0, 1'b0));
      // divide by zero
      send_req(make_req(CMD_DIV, WORD_MAX, 1'b0));
      send_req(make_req(CMD_PUSH, 32'sha5c3_3c5a, 1'b0));
      send_req(make_req(CMD_SPARE_HI, -1, 1'b1));
      send_req(make_req(CMD_TEST, '0, 1'b0));
      send_req(make_req(CMD_TEST, '0, 1'b0));
      send_req(make_req(CMD_TEST, '0, 1'b0));
      // truncation towards zero
      send_req(make_req(CMD_PUSH, -32'sd7, 1'b0));
      send_req(make_req(CMD_ENTER, 32'sd2, 1'b0));
      send_req(make_req(CMD_DIV, '0, 1'b0));
      send_req(make_req(CMD_PRINT, '0, 1'b0));
      send_req(make_req(CMD_SPARE_LO, WORD_MIN, 1'b0));
      send_req(make_req(CMD_POP, -1, 1'b0));
   endtask

   // well-formed instruction groups with random content, plus some noise
   task automatic run_random(input int count);
      req_type  burst [$];
      word_type v;
      int       sent;
      sent = 0;
      while (sent < count) begin
         burst.delete();
         if (last_depth > DEPTH_GUARD) begin
            repeat ($urandom_range(4, 12)) burst.push_back(make_req(CMD_POP, $urandom, 1'b0));
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  burst.push_back(make_req(pick_push(), pick_operand(), 1'b0));
                  burst.push_back(make_req(pick_push(), pick_operand(), 1'b0));
                  burst.push_back(make_req(ARITH_OPS[$urandom_range(0, 3)], $urandom, 1'b0));
                  repeat ($urandom_range(0, 3))
                     burst.push_back(make_req(CMD_POP, $urandom, 1'b0));
               end
               3: begin
                  v = pick_operand();
                  burst.push_back(make_req(pick_push(), v, 1'b0));
                  burst.push_back(make_req(pick_push(), v, 1'b0));
                  burst.push_back(make_req(CMD_TEST, $urandom, 1'b0));
                  burst.push_back(make_req(CMD_POP, $urandom, 1'b0));
               end
               4: begin
                  burst.push_back(make_req(pick_push(), $urandom, 1'b0));
                  burst.push_back(make_req(pick_push(), $urandom, 1'b0));
                  burst.push_back(make_req(CMD_W'($urandom_range(0, 15)), $urandom, 1'b1));
                  burst.push_back(make_req(CMD_POP, $urandom, 1'b0));
                  burst.push_back(make_req(CMD_POP, $urandom, 1'b0));
               end
               5: begin
                  burst.push_back(make_req(pick_push(), pick_operand(), 1'b0));
                  burst.push_back(make_req(pick_push(), '0, 1'b0));
                  burst.push_back(make_req(CMD_DIV, $urandom, 1'b0));
                  burst.push_back(make_req(CMD_POP, $urandom, 1'b0));
                  burst.push_back(make_req(CMD_POP, $urandom, 1'b0));
               end
               6: begin
                  burst.push_back(make_req(pick_push(), WORD_MIN, 1'b0));
                  burst.push_back(make_req(pick_push(), -1, 1'b0));
                  burst.push_back(make_req(CMD_DIV, $urandom, 1'b0));
                  burst.push_back(make_req(CMD_PRINT, $urandom, 1'b0));
               end
               default: begin
                  repeat ($urandom_range(1, 3))
                     burst.push_back(make_req(CMD_W'($urandom_range(0, 15)), $urandom,
                                              $urandom_range(0, 7) == 0));
               end
            endcase
         end
         foreach (burst[i]) send_req(burst[i]);
         sent += burst.size();
      end
   endtask

   // exit, then every code once more against the halted machine
   task automatic run_halted();
      send_req(make_req(CMD_EXIT, $urandom, 1'b0));
      for (int c = 0; c < 16; c++)
         send_req(make_req(CMD_W'(c), $urandom, c[0]));
      send_req(make_req(CMD_EXIT, $urandom, 1'b0));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         req_idle_pct  = IDLE_PCT[p];
         rsp_stall_pct = STALL_PCT[p];
         // long receiver hold-off while the sender keeps offering
         if (p == 0) hold_requested = 1'b1;
         run_random(PHASE_ITEMS);
         wait_drained();
      end

      req_idle_pct  = 7;
      rsp_stall_pct = 7;
      run_halted();
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
